// ===== rtl/sorted_software_timer_queue_defines.svh =====
// Assertion macros for the sorted timer queue.
// Included by the top level; depends on nothing else.
`ifndef SORTED_SOFTWARE_TIMER_QUEUE_DEFINES_SVH
`define SORTED_SOFTWARE_TIMER_QUEUE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SSTQ_ASSERT_IMPL(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define SSTQ_ASSERT_NEXT(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/sstq_pkg.sv =====
// Types and constants of the sorted timer queue.
// No dependencies.
`default_nettype none

package sstq_pkg;

	localparam int SLOT_COUNT = 32;
	localparam int SLOT_W     = $clog2(SLOT_COUNT);
	localparam int TICK_W     = 32;
	localparam int QUEUE_W    = 8;
	localparam int PAY_W      = 32;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	localparam logic [TICK_W-1:0] ALL_ONES = '1;
	localparam logic [SLOT_W-1:0] SENTINEL = '0;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

	// register index, taken from paddr[2]
	localparam logic REG_TASK_SLOT = 1'b0;

	typedef enum logic [2:0] {
		OP_ALLOC       = 3'd0,
		OP_FREE        = 3'd1,
		OP_SET_HANDLER = 3'd2,
		OP_SET_TIME    = 3'd3,
		OP_CANCEL      = 3'd4,
		OP_CANCEL_ALL  = 3'd5,
		OP_TICK        = 3'd6
	} op_t;

	typedef enum logic [2:0] {
		K_ACK         = 3'd0,
		K_ALLOC_OK    = 3'd1,
		K_ALLOC_FAIL  = 3'd2,
		K_CANCELLED   = 3'd3,
		K_NOT_RUNNING = 3'd4,
		K_DELIVER     = 3'd5,
		K_TASK_SWITCH = 3'd6
	} kind_t;

	typedef enum logic [1:0] {
		ST_FREE  = 2'd0,
		ST_ALLOC = 2'd1,
		ST_RUN   = 2'd2
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/sorted_software_timer_queue.sv =====
// Sorted timer queue: 31 timer slots (slot 0 is the list sentinel), running ones kept in a deadline-ordered list.
// Ack-only ops end in S_EXEC; alloc scans the slots in order; cancel and free
// unlink a running slot; set_time unlinks then inserts (one list step per cycle);
// cancel_all reads and checks each slot in turn, plus an unlink walk per match; tick
// walks the expired slots, with an extra task-switch result after a delivery.
// Rate is set by the single read port of the link and deadline RAMs.
// One item at a time; results come out one per strobe and cannot be held off.
// Async reset clears slot status, list head, tick count and task_slot; RAMs keep contents.
// Depends on sstq_pkg and sorted_software_timer_queue_defines.svh.
`default_nettype none

`include "sorted_software_timer_queue_defines.svh"

module sorted_software_timer_queue
	import sstq_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	// command channel
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [2:0]          operation,
	input  wire logic [4:0]          slot_index,
	input  wire logic [7:0]          queue_id,
	input  wire logic [31:0]         payload,
	input  wire logic                auto_cancel,
	input  wire logic [31:0]         delay,
	// results
	output logic                     valid,
	output logic [2:0]               kind,
	output logic [4:0]               result_slot,
	output logic [7:0]               result_queue,
	output logic [31:0]              result_payload,
	output logic                     last,
	// config
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [PADDR_W-1:0]  paddr,
	input  wire logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]       prdata,
	output logic                     pready
);

	typedef enum logic [4:0] {
		S_IDLE, S_EXEC, S_ALLOC, S_CA_RD, S_CA_CHK,
		S_UNL0, S_UNL1, S_UNL2, S_POST,
		S_INS0, S_INS1, S_INS2, S_INS3, S_INS4,
		S_T0, S_T1, S_TEND, S_TTS
	} state_t;

	state_t                   state_q;
	op_t                      op_q;
	logic [SLOT_W-1:0]        idx_q;
	logic [QUEUE_W-1:0]       qid_q;
	logic [PAY_W-1:0]         pay_in_q;
	logic                     ac_in_q;
	logic [TICK_W-1:0]        dl_q;
	logic [TICK_W-1:0]        tick_q;
	logic [SLOT_W-1:0]        head_q;
	logic [SLOT_W-1:0]        task_q;
	logic [SLOT_W-1:0]        cur_q;
	logic [SLOT_W-1:0]        nx_q;
	logic [SLOT_W-1:0]        links_q;
	logic                     pend_q;
	logic                     ts_q;
	logic [SLOT_W-1:0]        pend_slot_q;
	logic [QUEUE_W-1:0]       pend_queue_q;
	logic [PAY_W-1:0]         pend_pay_q;
	status_t                  status_q [SLOT_COUNT];
	logic                     acflag_q [SLOT_COUNT];

	logic                     valid_q;
	kind_t                    kind_q;
	logic [SLOT_W-1:0]        rslot_q;
	logic [QUEUE_W-1:0]       rqueue_q;
	logic [PAY_W-1:0]         rpay_q;
	logic                     last_q;

	// slot RAMs
	logic [TICK_W-1:0]        dl_mem  [SLOT_COUNT];
	logic [SLOT_W-1:0]        lnk_mem [SLOT_COUNT];
	logic [QUEUE_W+PAY_W-1:0] hdl_mem [SLOT_COUNT];
	logic [TICK_W-1:0]        dl_rd_q;
	logic [SLOT_W-1:0]        lnk_rd_q;
	logic [QUEUE_W+PAY_W-1:0] hdl_rd_q;

	logic [SLOT_W-1:0]        dl_ra, lnk_ra, hdl_ra, lnk_wa, lnk_wd;
	logic                     dl_we, lnk_we, hdl_we;

	status_t                  st_cur;
	logic                     ok;
	logic [TICK_W-1:0]        dl_head, dl_nx;
	logic [QUEUE_W-1:0]       hdl_queue;
	logic                     ca_match;
	logic                     expire;
	logic                     cfg_wr;

	assign st_cur    = status_q[idx_q];
	assign ok        = (idx_q != SENTINEL) && ((SLOT_W + 1)'(idx_q) < (SLOT_W + 1)'(SLOT_COUNT));
	// sentinel deadline is never stored; it reads as all ones
	assign dl_head   = (head_q == SENTINEL) ? ALL_ONES : dl_rd_q;
	assign dl_nx     = (nx_q == SENTINEL) ? ALL_ONES : dl_rd_q;
	assign hdl_queue = hdl_rd_q[QUEUE_W+PAY_W-1:PAY_W];
	assign ca_match  = (st_cur != ST_FREE) && acflag_q[idx_q] && (hdl_queue == qid_q);
	assign expire    = (nx_q != SENTINEL) && (tick_q >= dl_rd_q);

	// RAM port control
	always_comb begin
		dl_ra  = head_q;
		lnk_ra = head_q;
		hdl_ra = idx_q;
		dl_we  = 1'b0;
		lnk_we = 1'b0;
		hdl_we = 1'b0;
		lnk_wa = idx_q;
		lnk_wd = head_q;
		case (state_q)
			S_EXEC: begin
				hdl_we = (op_q == OP_SET_HANDLER) && ok;
			end
			S_UNL0: begin
				lnk_ra = idx_q;
			end
			S_UNL2: begin
				lnk_ra = lnk_rd_q;
				if (lnk_rd_q == idx_q) begin
					lnk_we = 1'b1;
					lnk_wa = cur_q;
					lnk_wd = links_q;
				end
			end
			S_INS0: begin
				dl_we = 1'b1;
			end
			S_INS1: begin
				lnk_we = (dl_q <= dl_head);
			end
			S_INS2: begin
				dl_ra  = lnk_rd_q;
				lnk_ra = lnk_rd_q;
			end
			S_INS3: begin
				dl_ra  = lnk_rd_q;
				lnk_ra = lnk_rd_q;
				if (dl_q <= dl_nx) begin
					lnk_we = 1'b1;
					lnk_wd = nx_q;
				end
			end
			S_INS4: begin
				lnk_we = 1'b1;
				lnk_wa = cur_q;
				lnk_wd = idx_q;
			end
			S_T0: begin
				hdl_ra = head_q;
			end
			S_T1: begin
				dl_ra  = lnk_rd_q;
				lnk_ra = lnk_rd_q;
				hdl_ra = lnk_rd_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (dl_we)
			dl_mem[idx_q] <= dl_q;
		dl_rd_q <= dl_mem[dl_ra];
	end

	always_ff @(posedge clk) begin
		if (lnk_we)
			lnk_mem[lnk_wa] <= lnk_wd;
		lnk_rd_q <= lnk_mem[lnk_ra];
	end

	always_ff @(posedge clk) begin
		if (hdl_we)
			hdl_mem[idx_q] <= {qid_q, pay_in_q};
		hdl_rd_q <= hdl_mem[hdl_ra];
	end

	// config register
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TASK_SLOT) ? PDATA_W'(task_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_q <= '0;
		end else if (cfg_wr && (paddr[2] == REG_TASK_SLOT)) begin
			task_q <= pwdata[SLOT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_ALLOC;
			idx_q        <= '0;
			qid_q        <= '0;
			pay_in_q     <= '0;
			ac_in_q      <= 1'b0;
			dl_q         <= '0;
			tick_q       <= '0;
			head_q       <= SENTINEL;
			cur_q        <= '0;
			nx_q         <= '0;
			links_q      <= '0;
			pend_q       <= 1'b0;
			ts_q         <= 1'b0;
			pend_slot_q  <= '0;
			pend_queue_q <= '0;
			pend_pay_q   <= '0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				status_q[i] <= (i == 0) ? ST_RUN : ST_FREE;
				acflag_q[i] <= 1'b0;
			end
			valid_q      <= 1'b0;
			kind_q       <= K_ACK;
			rslot_q      <= '0;
			rqueue_q     <= '0;
			rpay_q       <= '0;
			last_q       <= 1'b1;
		end else begin
			// result defaults: an ack; each result overrides what differs
			valid_q  <= 1'b0;
			kind_q   <= K_ACK;
			rslot_q  <= '0;
			rqueue_q <= '0;
			rpay_q   <= '0;
			last_q   <= 1'b1;

			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q     <= op_t'(operation);
						idx_q    <= slot_index;
						qid_q    <= queue_id;
						pay_in_q <= payload;
						ac_in_q  <= auto_cancel;
						dl_q     <= tick_q + delay;
						if (op_t'(operation) == OP_TICK)
							tick_q <= tick_q + 1'b1;
						state_q  <= S_EXEC;
					end
				end

				S_EXEC: begin
					case (op_q)
						OP_ALLOC: begin
							idx_q   <= SLOT_W'(1);
							state_q <= S_ALLOC;
						end
						OP_FREE: begin
							if (ok && st_cur == ST_RUN) begin
								state_q <= S_UNL0;
							end else begin
								if (ok)
									status_q[idx_q] <= ST_FREE;
								valid_q <= 1'b1;
								state_q <= S_IDLE;
							end
						end
						OP_SET_HANDLER: begin
							if (ok)
								acflag_q[idx_q] <= ac_in_q;
							valid_q <= 1'b1;
							state_q <= S_IDLE;
						end
						OP_SET_TIME: begin
							if (ok && st_cur == ST_RUN) begin
								state_q <= S_UNL0;
							end else if (ok && st_cur != ST_FREE) begin
								state_q <= S_INS0;
							end else begin
								valid_q <= 1'b1;
								state_q <= S_IDLE;
							end
						end
						OP_CANCEL: begin
							if (ok && st_cur == ST_RUN) begin
								state_q <= S_UNL0;
							end else begin
								valid_q <= 1'b1;
								kind_q  <= K_NOT_RUNNING;
								state_q <= S_IDLE;
							end
						end
						OP_CANCEL_ALL: begin
							idx_q   <= SLOT_W'(1);
							state_q <= S_CA_RD;
						end
						OP_TICK: begin
							state_q <= S_T0;
						end
						default: begin
							valid_q <= 1'b1;
							state_q <= S_IDLE;
						end
					endcase
				end

				S_ALLOC: begin
					if (st_cur == ST_FREE) begin
						status_q[idx_q] <= ST_ALLOC;
						acflag_q[idx_q] <= 1'b0;
						valid_q <= 1'b1;
						kind_q  <= K_ALLOC_OK;
						rslot_q <= idx_q;
						state_q <= S_IDLE;
					end else if (idx_q == LAST_SLOT) begin
						valid_q <= 1'b1;
						kind_q  <= K_ALLOC_FAIL;
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end

				S_CA_RD: begin
					state_q <= S_CA_CHK;
				end

				S_CA_CHK: begin
					if (ca_match && st_cur == ST_RUN) begin
						state_q <= S_UNL0;
					end else begin
						if (ca_match)
							status_q[idx_q] <= ST_FREE;
						if (idx_q == LAST_SLOT) begin
							valid_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_CA_RD;
						end
					end
				end

				// unlink idx_q from the list
				S_UNL0: begin
					state_q <= S_UNL1;
				end

				S_UNL1: begin
					links_q <= lnk_rd_q;
					if (head_q == idx_q) begin
						head_q  <= lnk_rd_q;
						state_q <= S_POST;
					end else begin
						cur_q   <= head_q;
						state_q <= S_UNL2;
					end
				end

				S_UNL2: begin
					if (lnk_rd_q == idx_q)
						state_q <= S_POST;
					else
						cur_q <= lnk_rd_q;
				end

				S_POST: begin
					case (op_q)
						OP_FREE: begin
							status_q[idx_q] <= ST_FREE;
							valid_q <= 1'b1;
							state_q <= S_IDLE;
						end
						OP_SET_TIME: begin
							state_q <= S_INS0;
						end
						OP_CANCEL: begin
							status_q[idx_q] <= ST_ALLOC;
							valid_q <= 1'b1;
							kind_q  <= K_CANCELLED;
							state_q <= S_IDLE;
						end
						OP_CANCEL_ALL: begin
							status_q[idx_q] <= ST_FREE;
							if (idx_q == LAST_SLOT) begin
								valid_q <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								idx_q   <= idx_q + 1'b1;
								state_q <= S_CA_RD;
							end
						end
						default: begin
							valid_q <= 1'b1;
							state_q <= S_IDLE;
						end
					endcase
				end

				// insert idx_q ahead of the first slot with deadline >= dl_q
				S_INS0: begin
					status_q[idx_q] <= ST_RUN;
					state_q <= S_INS1;
				end

				S_INS1: begin
					if (dl_q <= dl_head) begin
						head_q  <= idx_q;
						valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						cur_q   <= head_q;
						state_q <= S_INS2;
					end
				end

				S_INS2: begin
					nx_q    <= lnk_rd_q;
					state_q <= S_INS3;
				end

				S_INS3: begin
					if (dl_q <= dl_nx) begin
						state_q <= S_INS4;
					end else begin
						cur_q <= nx_q;
						nx_q  <= lnk_rd_q;
					end
				end

				S_INS4: begin
					valid_q <= 1'b1;
					state_q <= S_IDLE;
				end

				// expiry walk from the head; deliveries are held one step so the
				// final one can carry last
				S_T0: begin
					nx_q    <= head_q;
					pend_q  <= 1'b0;
					ts_q    <= 1'b0;
					state_q <= S_T1;
				end

				S_T1: begin
					if (expire) begin
						status_q[nx_q] <= ST_ALLOC;
						if (nx_q == task_q) begin
							ts_q <= 1'b1;
						end else begin
							if (pend_q) begin
								valid_q  <= 1'b1;
								kind_q   <= K_DELIVER;
								rslot_q  <= pend_slot_q;
								rqueue_q <= pend_queue_q;
								rpay_q   <= pend_pay_q;
								last_q   <= 1'b0;
							end
							pend_q       <= 1'b1;
							pend_slot_q  <= nx_q;
							pend_queue_q <= hdl_queue;
							pend_pay_q   <= hdl_rd_q[PAY_W-1:0];
						end
						head_q <= lnk_rd_q;
						nx_q   <= lnk_rd_q;
					end else begin
						state_q <= S_TEND;
					end
				end

				S_TEND: begin
					valid_q <= 1'b1;
					if (pend_q) begin
						kind_q   <= K_DELIVER;
						rslot_q  <= pend_slot_q;
						rqueue_q <= pend_queue_q;
						rpay_q   <= pend_pay_q;
						last_q   <= !ts_q;
						state_q  <= ts_q ? S_TTS : S_IDLE;
					end else if (ts_q) begin
						kind_q  <= K_TASK_SWITCH;
						rslot_q <= task_q;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_IDLE;
					end
				end

				S_TTS: begin
					valid_q <= 1'b1;
					kind_q  <= K_TASK_SWITCH;
					rslot_q <= task_q;
					state_q <= S_IDLE;
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy           = (state_q != S_IDLE);
	assign valid          = valid_q;
	assign kind           = kind_q;
	assign result_slot    = rslot_q;
	assign result_queue   = rqueue_q;
	assign result_payload = rpay_q;
	assign last           = last_q;

	`SSTQ_ASSERT_IMPL(a_sentinel_running, clk, arst_n, 1'b1, status_q[0] == ST_RUN, "sentinel slot left running state")
	`SSTQ_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accepted command did not raise busy")
	`SSTQ_ASSERT_IMPL(a_done_last, clk, arst_n, $fell(busy), valid && last, "command ended without a final result")
	`SSTQ_ASSERT_IMPL(a_deliver_slot, clk, arst_n, valid && kind == K_DELIVER, result_slot != SENTINEL, "delivery from sentinel slot")

endmodule

`default_nettype wire
